### rtl/core/thr_pkg.sv
// ----------------------------------------------------------------------------
// thr_pkg
// Shared types, constants and the microcode table of the time-stamped
// history ring.
// ----------------------------------------------------------------------------
package thr_pkg;

    // default ring depth
    localparam int unsigned DEPTH_DEF = 512;

    // item and entry widths
    localparam int unsigned STAMP_W = 64;
    localparam int unsigned ENTRY_W = 256;
    localparam int unsigned IN_W    = 320;
    localparam int unsigned OUT_W   = 256;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OLD   = 2'd2;

    // microprogram step addresses
    typedef logic [3:0] t_pc;
    localparam t_pc PC_FETCH      = 4'd0;
    localparam t_pc PC_DISPATCH   = 4'd1;
    localparam t_pc PC_WR_COMMIT  = 4'd2;
    localparam t_pc PC_RD_CHECK   = 4'd3;
    localparam t_pc PC_RD_START   = 4'd4;
    localparam t_pc PC_RD_WALK    = 4'd5;
    localparam t_pc PC_POST_FOUND = 4'd6;
    localparam t_pc PC_POST_EMPTY = 4'd7;
    localparam t_pc PC_POST_OLD   = 4'd8;

    // jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_OP_READ,
        C_EMPTY,
        C_OLDER,
        C_MISS
    } t_cond;

    // one control word
    typedef struct packed {
        logic       accept;     // take a request from the input side
        logic       rd_next;    // read the entry after the write slot
        logic       walk_init;  // clamp query, start walk at newest entry
        logic       walk_step;  // capture entry, step walk backward
        logic       wr_commit;  // store sample and update ring state
        logic       post;       // load the output register
        logic       res_found;  // posted data comes from captured entry
        logic [1:0] status;
        t_cond      cond;
        t_pc        target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic req;
        logic op_read;
        logic empty;
        logic older;
        logic miss;
        logic out_free;
    } t_flags;

    // microcode table
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = PC_FETCH;
        case (pc)
            PC_FETCH: begin
                w.accept = 1'b1;
                w.cond   = C_NO_REQ;
                w.target = PC_FETCH;
            end
            PC_DISPATCH: begin
                w.rd_next = 1'b1;
                w.cond    = C_OP_READ;
                w.target  = PC_RD_CHECK;
            end
            PC_WR_COMMIT: begin
                w.wr_commit = 1'b1;
                w.post      = 1'b1;
                w.status    = ST_OK;
            end
            PC_RD_CHECK: begin
                w.cond   = C_EMPTY;
                w.target = PC_POST_EMPTY;
            end
            PC_RD_START: begin
                w.walk_init = 1'b1;
                w.cond      = C_OLDER;
                w.target    = PC_POST_OLD;
            end
            PC_RD_WALK: begin
                w.walk_step = 1'b1;
                w.cond      = C_MISS;
                w.target    = PC_RD_WALK;
            end
            PC_POST_FOUND: begin
                w.post      = 1'b1;
                w.res_found = 1'b1;
                w.status    = ST_OK;
            end
            PC_POST_EMPTY: begin
                w.post   = 1'b1;
                w.status = ST_EMPTY;
            end
            PC_POST_OLD: begin
                w.post   = 1'b1;
                w.status = ST_OLD;
            end
            default: begin
                w.target = PC_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/core/thr_ram.sv
// ----------------------------------------------------------------------------
// thr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module thr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/thr_seq.sv
// ----------------------------------------------------------------------------
// thr_seq
// Microprogram sequencer: step counter, control word fetch and jumps.
// ----------------------------------------------------------------------------
module thr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thr_pkg::t_flags i_flags,
    output thr_pkg::t_uword o_uw,
    output logic            o_exec
);
    import thr_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_stall;
    logic   w_taken;

    // control word for the current step
    assign w_uw = ucode(r_pc);

    // a posting step waits for the output register
    assign w_stall = w_uw.post && !i_flags.out_free;

    // jump condition
    always_comb begin
        case (w_uw.cond)
            C_ALWAYS:  w_taken = 1'b1;
            C_NO_REQ:  w_taken = !i_flags.req;
            C_OP_READ: w_taken = i_flags.op_read;
            C_EMPTY:   w_taken = i_flags.empty;
            C_OLDER:   w_taken = i_flags.older;
            C_MISS:    w_taken = i_flags.miss;
            default:   w_taken = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_taken) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw   = w_uw;
    assign o_exec = !w_stall;

endmodule

### rtl/core/thr_dp.sv
// ----------------------------------------------------------------------------
// thr_dp
// Ring datapath: sample memory, pointers, time bounds, backward walk and
// output register, all driven by the control word.
// ----------------------------------------------------------------------------
module thr_dp #(
    parameter int unsigned DEPTH = thr_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  thr_pkg::t_uword          i_uw,
    input  logic                     i_exec,
    output thr_pkg::t_flags          o_flags,
    input  logic                     i_s_tvalid,
    input  logic [thr_pkg::IN_W-1:0] i_s_tdata,
    input  logic                     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [thr_pkg::OUT_W-1:0] o_m_tdata,
    output logic [1:0]               o_m_tuser
);
    import thr_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // ring state
    logic [AW-1:0]      r_wptr;
    logic [CW-1:0]      r_count;
    logic [STAMP_W-1:0] r_newest;
    logic [STAMP_W-1:0] r_oldest;

    // request registers
    logic               r_op;
    logic [IN_W-1:0]    r_in_data;
    logic [STAMP_W-1:0] r_query;

    // walk registers
    logic [AW-1:0]      r_cursor;
    logic [CW-1:0]      r_remain;
    logic [ENTRY_W-1:0] r_found;

    // output register
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [1:0]         r_out_status;

    logic [ENTRY_W-1:0] w_rd_data;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [AW-1:0]      w_rd_addr;
    logic               w_rd_en;
    logic               w_wr_en;
    logic [AW-1:0]      w_wptr_next;
    logic [AW-1:0]      w_wptr_prev;
    logic [AW-1:0]      w_cursor_prev;
    logic [STAMP_W-1:0] w_new_stamp;
    logic [STAMP_W-1:0] w_oldest_base;
    logic               w_accept;
    logic               w_out_free;

    // neighbor slots with wrap
    assign w_wptr_next   = (r_wptr == LAST_SLOT) ? '0 : r_wptr + AW'(1);
    assign w_wptr_prev   = (r_wptr == '0) ? LAST_SLOT : r_wptr - AW'(1);
    assign w_cursor_prev = (r_cursor == '0) ? LAST_SLOT : r_cursor - AW'(1);

    // memory port control
    assign w_rd_en   = i_exec && (i_uw.rd_next || i_uw.walk_init || i_uw.walk_step);
    assign w_rd_addr = i_uw.rd_next   ? w_wptr_next :
                       i_uw.walk_init ? w_wptr_prev : w_cursor_prev;
    assign w_wr_en   = i_exec && i_uw.wr_commit;
    assign w_wr_data = {r_in_data[IN_W-1:2*STAMP_W], r_in_data[STAMP_W-1:0]};

    thr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // oldest time after a write, before the decreasing-time check
    assign w_new_stamp = r_in_data[STAMP_W-1:0];
    always_comb begin
        if (r_count == '0) begin
            w_oldest_base = w_new_stamp;
        end else if (r_count == FULL_CNT) begin
            w_oldest_base = w_rd_data[STAMP_W-1:0];
        end else begin
            w_oldest_base = r_oldest;
        end
    end

    assign w_accept   = i_uw.accept && i_s_tvalid;
    assign w_out_free = !r_out_valid || i_m_tready;

    // status to the sequencer
    assign o_flags.req      = i_s_tvalid;
    assign o_flags.op_read  = r_op;
    assign o_flags.empty    = (r_count == '0);
    assign o_flags.older    = (r_query < r_oldest);
    assign o_flags.miss     = (w_rd_data[STAMP_W-1:0] > r_query) && (r_remain != '0);
    assign o_flags.out_free = w_out_free;

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
    end

    // query register, clamped to the newest time at walk start
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= i_s_tdata[2*STAMP_W-1:STAMP_W];
        end else if (i_exec && i_uw.walk_init && (r_query > r_newest)) begin
            r_query <= r_newest;
        end
    end

    // backward walk
    always_ff @(posedge i_clk) begin
        if (i_exec && i_uw.walk_init) begin
            r_cursor <= w_wptr_prev;
            r_remain <= r_count - CW'(1);
        end else if (i_exec && i_uw.walk_step) begin
            r_cursor <= w_cursor_prev;
            r_remain <= r_remain - CW'(1);
            r_found  <= w_rd_data;
        end
    end

    // ring state update on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_count  <= '0;
            r_newest <= '0;
            r_oldest <= '0;
        end else if (w_wr_en) begin
            r_wptr   <= w_wptr_next;
            r_newest <= w_new_stamp;
            if (r_count != FULL_CNT) begin
                r_count <= r_count + CW'(1);
            end
            if (w_new_stamp < w_oldest_base) begin
                r_oldest <= w_new_stamp;
            end else begin
                r_oldest <= w_oldest_base;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_exec && i_uw.post) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && i_uw.post) begin
            r_out_status <= i_uw.status;
            r_out_data   <= i_uw.res_found ? r_found : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTHESIS
    // fill count never passes the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("stored count above depth");

    // bounds stay ordered once anything is stored
    a_bound_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_oldest <= r_newest))
        else $error("oldest time after newest time");

    // the count moves only through a committed write
    a_count_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> $past(i_exec && i_uw.wr_commit))
        else $error("stored count changed without a write");

    // a held result is never overwritten
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && i_uw.post) |-> (!r_out_valid || i_m_tready))
        else $error("result posted over a pending one");
`endif

endmodule

### rtl/core/timestamped_history_ring.sv
// ----------------------------------------------------------------------------
// timestamped_history_ring
// Circular history of time-stamped position samples with lookup by time.
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   sample_time, query_time, x_tilt, y_tilt,    operation
//                z_focus, set_x, set_y, set_z  (320 bits)
//  m_axis   out  found_time, found_x_tilt, found_y_tilt,     status
//                found_z_focus, found_set_x, found_set_y,
//                found_set_z  (256 bits)
//
// A write runs fetch, dispatch, commit; a read runs fetch, dispatch, empty
// check, then posts empty, or starts the walk and posts old, or walks 1 up to
// the stored count of samples (at most DEPTH), one memory read per cycle, and
// posts found. Reset clears pointers, count and time bounds; the sample memory
// is not cleared and needs no clearing pass. A new request is taken while a
// result waits in the output register; the next post stalls until it is taken.
// ----------------------------------------------------------------------------
module timestamped_history_ring #(
    parameter int unsigned DEPTH = thr_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample_time, query_time, x_tilt, y_tilt, z_focus, set_x, set_y, set_z
    input  logic [thr_pkg::IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic                      s_axis_tuser,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // found_time, found_x_tilt, found_y_tilt, found_z_focus,
    // found_set_x, found_set_y, found_set_z
    output logic [thr_pkg::OUT_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]                m_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready
);
    import thr_pkg::*;

    t_uword w_uw;
    t_flags w_flags;
    logic   w_exec;

    // microprogram sequencer
    thr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uw    (w_uw),
        .o_exec  (w_exec)
    );

    // ring datapath
    thr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uw       (w_uw),
        .i_exec     (w_exec),
        .o_flags    (w_flags),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // requests are taken only in the fetch step
    assign s_axis_tready = w_uw.accept;

endmodule
